// ===== rtl/fpfa_pkg.sv =====
package fpfa_pkg;

    // default geometry of the partition table
    localparam int DEF_BLOCKS    = 16;
    localparam int DEF_SIZE_BITS = 16;

    // fixed widths of the item and result fields
    localparam int KIND_W  = 2;
    localparam int SLOT_W  = 4;
    localparam int REQ_W   = 16;
    localparam int FREE_W  = 20;
    localparam int CNT_W   = 16;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [FREE_W-1:0] FREE_MAX = {FREE_W{1'b1}};
    localparam logic [CNT_W-1:0]  CNT_MAX  = {CNT_W{1'b1}};

    // item kinds
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd2;

    // fit policies, the unused code behaves as first fit
    localparam logic [1:0] POL_FIRST = 2'd0;
    localparam logic [1:0] POL_BEST  = 2'd1;
    localparam logic [1:0] POL_WORST = 2'd2;

    // register index taken from paddr[2]
    localparam logic REG_FIT_POLICY = 1'b0;

    // partition table access for one cycle
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clear;
    } t_mem_ctl;

    // statistics update for one finished item
    typedef struct packed {
        logic upd;
        logic clear;
        logic load;
        logic load_repl;
        logic alloc_ok;
        logic alloc_fail;
    } t_stat_ctl;

endpackage

// ===== rtl/fpfa_regs.sv =====
module fpfa_regs
    import fpfa_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output logic [1:0]         o_fit_policy
);

    logic       w_wr_fire;
    logic [1:0] r_policy;

    assign pready    = 1'b1;
    assign w_wr_fire = psel && penable && pwrite && pready;

    // policy register write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy <= POL_FIRST;
        end else if (w_wr_fire && (paddr[2] == REG_FIT_POLICY)) begin
            r_policy <= pwdata[1:0];
        end
    end

    // read back, offsets with paddr[2] set read as zero
    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_FIT_POLICY) begin
            prdata = PDATA_W'(r_policy);
        end
    end

    assign o_fit_policy = r_policy;

endmodule

// ===== rtl/fpfa_mem.sv =====
module fpfa_mem
    import fpfa_pkg::*;
#(
    parameter int BLOCKS    = DEF_BLOCKS,
    parameter int SIZE_BITS = DEF_SIZE_BITS,
    parameter int AW        = $clog2(BLOCKS)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_mem_ctl             i_ctl,
    input  logic [AW-1:0]        i_rd_addr,
    input  logic [AW-1:0]        i_wr_addr,
    input  logic [SIZE_BITS-1:0] i_wr_data,
    output logic [SIZE_BITS-1:0] o_rd_data,
    output logic                 o_rd_valid
);

    logic [SIZE_BITS-1:0] r_mem [BLOCKS];
    logic [SIZE_BITS-1:0] r_rd_data;
    logic [BLOCKS-1:0]    r_valid;
    logic                 r_rd_valid;

    // remaining sizes, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // per-partition valid bits, an invalid entry is never chosen
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_ctl.clear) begin
                r_valid <= '0;
            end else if (i_ctl.wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_ctl.rd_en) begin
                r_rd_valid <= r_valid[i_rd_addr];
            end
        end
    end

    assign o_rd_data  = r_rd_data;
    assign o_rd_valid = r_rd_valid;

endmodule

// ===== rtl/fpfa_stats.sv =====
module fpfa_stats
    import fpfa_pkg::*;
#(
    parameter int BLOCKS    = DEF_BLOCKS,
    parameter int SIZE_BITS = DEF_SIZE_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_stat_ctl            i_ctl,
    input  logic [SIZE_BITS-1:0] i_size,
    input  logic [SIZE_BITS-1:0] i_old,
    output logic [FREE_W-1:0]    o_free_total_kb,
    output logic [CNT_W-1:0]     o_failed_count,
    output logic                 o_external_frag
);

    // exact free space never exceeds BLOCKS full partitions
    localparam int SUM_W = SIZE_BITS + $clog2(BLOCKS);
    localparam int SAT_W = SUM_W + FREE_W;
    localparam int CMP_W = SUM_W + SIZE_BITS;

    logic [SUM_W-1:0]     r_sum, n_sum;
    logic [CNT_W-1:0]     r_fail, n_fail;
    logic [SIZE_BITS-1:0] r_small, n_small;
    logic                 r_any, n_any;
    logic [FREE_W-1:0]    r_free, n_free;
    logic                 r_frag, n_frag;
    logic [SAT_W-1:0]     w_sum_sat;
    logic [SUM_W-1:0]     w_sub_old;

    assign w_sub_old = i_ctl.load_repl ? SUM_W'(i_old) : '0;

    // next statistics for the finishing item
    always_comb begin
        n_sum   = r_sum;
        n_fail  = r_fail;
        n_small = r_small;
        n_any   = r_any;
        if (i_ctl.clear) begin
            n_sum   = '0;
            n_fail  = '0;
            n_small = '1;
            n_any   = 1'b0;
        end else if (i_ctl.load) begin
            n_sum = r_sum - w_sub_old + SUM_W'(i_size);
        end else if (i_ctl.alloc_ok) begin
            n_sum = r_sum - SUM_W'(i_size);
        end else if (i_ctl.alloc_fail) begin
            if (r_fail != CNT_MAX) begin
                n_fail = r_fail + 1'b1;
            end
            if (!r_any || (i_size < r_small)) begin
                n_small = i_size;
            end
            n_any = 1'b1;
        end
    end

    // saturated total and fragmentation flag from the exact sum
    always_comb begin
        w_sum_sat = SAT_W'(n_sum);
        if (w_sum_sat > SAT_W'(FREE_MAX)) begin
            n_free = FREE_MAX;
        end else begin
            n_free = w_sum_sat[FREE_W-1:0];
        end
        n_frag = n_any && (CMP_W'(n_small) <= CMP_W'(n_sum));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_fail  <= '0;
            r_small <= '1;
            r_any   <= 1'b0;
            r_free  <= '0;
            r_frag  <= 1'b0;
        end else if (i_ctl.upd) begin
            r_sum   <= n_sum;
            r_fail  <= n_fail;
            r_small <= n_small;
            r_any   <= n_any;
            r_free  <= n_free;
            r_frag  <= n_frag;
        end
    end

    assign o_free_total_kb = r_free;
    assign o_failed_count  = r_fail;
    assign o_external_frag = r_frag;

endmodule

// ===== rtl/fixed_partition_fit_allocator.sv =====
// allocate: the table is scanned one read per cycle, then the chosen entry is written back
// clear, load and unused kinds: no scan (a load reads its entry, then write-back)
// one item at a time: the next transfer in waits until the write-back is done
// the write-back, and so the result, waits while the previous result is not yet taken
// synchronous active-low reset clears valid bits, statistics and fit policy;
// the size memory itself is not swept, invalid entries are never read as free space
module fixed_partition_fit_allocator
    import fpfa_pkg::*;
#(
    parameter int BLOCKS    = DEF_BLOCKS,
    parameter int SIZE_BITS = DEF_SIZE_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [KIND_W-1:0]  i_kind,
    input  logic [SLOT_W-1:0]  i_block_slot,
    input  logic [REQ_W-1:0]   i_size_kb,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_allocated,
    output logic [SLOT_W-1:0]  o_block_index,
    output logic [REQ_W-1:0]   o_leftover_kb,
    output logic [FREE_W-1:0]  o_free_total_kb,
    output logic [CNT_W-1:0]   o_failed_count,
    output logic               o_external_frag
);

    localparam int AW = $clog2(BLOCKS);
    localparam logic [AW-1:0] LAST = AW'(BLOCKS - 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_WB   = 2'd2;

    logic [1:0]           r_state, n_state;
    logic [KIND_W-1:0]    r_kind;
    logic [SIZE_BITS-1:0] r_size;
    logic [AW-1:0]        r_slot;
    logic                 r_slot_ok;
    logic [AW-1:0]        r_cmp;
    logic                 r_found;
    logic [AW-1:0]        r_best;
    logic [SIZE_BITS-1:0] r_best_val;
    logic                 r_o_valid;
    logic                 r_o_alloc;
    logic [SLOT_W-1:0]    r_o_index;
    logic [REQ_W-1:0]     r_o_left;

    logic [1:0]           w_policy;
    logic                 w_accept;
    logic                 w_out_free;
    logic                 w_finish;
    logic                 w_fits;
    logic                 w_take;
    logic                 w_slot_ok;
    logic [31:0]          w_slot_wide;
    logic [AW+SLOT_W-1:0] w_slot_ext;
    logic [SIZE_BITS+REQ_W-1:0] w_size_ext;
    logic [SIZE_BITS-1:0] w_req;
    logic [SIZE_BITS-1:0] w_left;
    logic [SIZE_BITS+REQ_W-1:0] w_left_ext;
    logic [AW+SLOT_W-1:0] w_best_ext;
    logic                 w_is_alloc;

    t_mem_ctl             w_mem_ctl;
    logic [AW-1:0]        w_rd_addr;
    logic [AW-1:0]        w_wr_addr;
    logic [SIZE_BITS-1:0] w_wr_data;
    logic [SIZE_BITS-1:0] w_rd_data;
    logic                 w_rd_valid;
    t_stat_ctl            w_stat_ctl;

    fpfa_regs u_regs (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_fit_policy (w_policy)
    );

    fpfa_mem #(
        .BLOCKS    (BLOCKS),
        .SIZE_BITS (SIZE_BITS),
        .AW        (AW)
    ) u_mem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_mem_ctl),
        .i_rd_addr  (w_rd_addr),
        .i_wr_addr  (w_wr_addr),
        .i_wr_data  (w_wr_data),
        .o_rd_data  (w_rd_data),
        .o_rd_valid (w_rd_valid)
    );

    fpfa_stats #(
        .BLOCKS    (BLOCKS),
        .SIZE_BITS (SIZE_BITS)
    ) u_stats (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (w_stat_ctl),
        .i_size          (r_size),
        .i_old           (w_rd_data),
        .o_free_total_kb (o_free_total_kb),
        .o_failed_count  (o_failed_count),
        .o_external_frag (o_external_frag)
    );

    // input transfer and field conditioning
    assign o_ready     = (r_state == S_IDLE);
    assign w_accept    = i_valid && o_ready;
    assign w_slot_wide = 32'(i_block_slot);
    assign w_slot_ok   = (w_slot_wide < 32'(BLOCKS));
    assign w_slot_ext  = (AW + SLOT_W)'(i_block_slot);
    assign w_size_ext  = (SIZE_BITS + REQ_W)'(i_size_kb);
    assign w_req       = w_size_ext[SIZE_BITS-1:0];

    // the write-back waits until the output register can take the result
    assign w_out_free = !r_o_valid || i_ready;
    assign w_finish   = (r_state == S_WB) && w_out_free;
    assign w_is_alloc = (r_kind == KIND_ALLOC);

    // scan compare against the entry read last cycle
    assign w_fits = w_rd_valid && (w_rd_data >= r_size);
    always_comb begin
        w_take = 1'b0;
        if (w_fits) begin
            if (!r_found) begin
                w_take = 1'b1;
            end else if (w_policy == POL_BEST) begin
                w_take = (w_rd_data < r_best_val);
            end else if (w_policy == POL_WORST) begin
                w_take = (w_rd_data > r_best_val);
            end
        end
    end

    assign w_left     = r_best_val - r_size;
    assign w_left_ext = (SIZE_BITS + REQ_W)'(w_left);
    assign w_best_ext = (AW + SLOT_W)'(r_best);

    // table access: one read per cycle while scanning, write-back at the end
    always_comb begin
        w_mem_ctl = '0;
        w_rd_addr = r_cmp + 1'b1;
        w_wr_addr = r_slot;
        w_wr_data = r_size;
        if (r_state == S_IDLE) begin
            w_mem_ctl.rd_en = w_accept && ((i_kind == KIND_ALLOC)
                              || ((i_kind == KIND_LOAD) && w_slot_ok));
            w_rd_addr = (i_kind == KIND_ALLOC) ? '0 : w_slot_ext[AW-1:0];
        end else if (r_state == S_SCAN) begin
            w_mem_ctl.rd_en = (r_cmp != LAST);
        end
        if (w_finish) begin
            w_mem_ctl.clear = (r_kind == KIND_CLEAR);
            if ((r_kind == KIND_LOAD) && r_slot_ok) begin
                w_mem_ctl.wr_en = 1'b1;
            end else if (w_is_alloc && r_found) begin
                w_mem_ctl.wr_en = 1'b1;
                w_wr_addr       = r_best;
                w_wr_data       = w_left;
            end
        end
    end

    // statistics update travels with the result
    always_comb begin
        w_stat_ctl            = '0;
        w_stat_ctl.upd        = w_finish;
        w_stat_ctl.clear      = (r_kind == KIND_CLEAR);
        w_stat_ctl.load       = (r_kind == KIND_LOAD) && r_slot_ok;
        w_stat_ctl.load_repl  = w_rd_valid;
        w_stat_ctl.alloc_ok   = w_is_alloc && r_found;
        w_stat_ctl.alloc_fail = w_is_alloc && !r_found;
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = (i_kind == KIND_ALLOC) ? S_SCAN : S_WB;
                end
            end
            S_SCAN: begin
                if (r_cmp == LAST) begin
                    n_state = S_WB;
                end
            end
            S_WB: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_found <= 1'b0;
            r_cmp   <= '0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_found <= 1'b0;
                r_cmp   <= '0;
            end else if (r_state == S_SCAN) begin
                r_cmp <= r_cmp + 1'b1;
                if (w_take) begin
                    r_found <= 1'b1;
                end
            end
        end
    end

    // item fields and current candidate
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind    <= i_kind;
            r_size    <= w_req;
            r_slot    <= w_slot_ext[AW-1:0];
            r_slot_ok <= w_slot_ok;
        end
        if ((r_state == S_SCAN) && w_take) begin
            r_best     <= r_cmp;
            r_best_val <= w_rd_data;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_finish) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_finish) begin
            r_o_alloc <= w_is_alloc && r_found;
            r_o_index <= (w_is_alloc && r_found) ? w_best_ext[SLOT_W-1:0] : '0;
            r_o_left  <= (w_is_alloc && r_found) ? w_left_ext[REQ_W-1:0] : '0;
        end
    end

    assign o_valid       = r_o_valid;
    assign o_allocated   = r_o_alloc;
    assign o_block_index = r_o_index;
    assign o_leftover_kb = r_o_left;

    // a new result only comes out of the write-back step
    a_result_from_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state) == S_WB)
        else $error("result appeared without a write-back");

    // a result is never overwritten while it waits
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |-> !w_finish)
        else $error("write-back while result still pending");

    // the chosen block is a valid partition that holds the request
    a_choice_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && w_take) |-> (w_rd_valid && w_rd_data >= r_size))
        else $error("scan picked a block that does not fit");

    // the scan pointer stays inside the table
    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (32'(r_cmp) < 32'(BLOCKS)))
        else $error("scan pointer beyond the table");

    // a taken item always leaves the idle state
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state != S_IDLE))
        else $error("item transfer without work");

endmodule
